// ----- design/aes_pkg.sv -----
package aes_pkg;

    typedef logic [127:0] blk_t;
    typedef logic [7:0] sbox_t [256];
    typedef logic [7:0] rcon_t [10];

    typedef struct packed {
        logic vld;
        logic kind;
        logic fin;
    } ctl_t;

    localparam int NUM_ROUNDS = 10;
    localparam logic KIND_DECRYPT = 1'b1;
    localparam logic [1:0] REG_KEY_FIRST = 2'd0;
    localparam logic [1:0] REG_KEY_SECOND = 2'd1;

    localparam rcon_t RCON = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                               8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

    localparam sbox_t SBOX = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // invert the forward table at elaboration
    function automatic sbox_t inv_table();
        sbox_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[SBOX[i]] = 8'(i);
        end
        return t;
    endfunction

    localparam sbox_t INV_SBOX = inv_table();

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[31:24];
        a1 = c[23:16];
        a2 = c[15:8];
        a3 = c[7:0];
        return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] a [4];
        logic [7:0] m9 [4];
        logic [7:0] m11 [4];
        logic [7:0] m13 [4];
        logic [7:0] m14 [4];
        logic [7:0] x2, x4, x8;
        for (int j = 0; j < 4; j++)
        begin
            a[j] = c[31 - 8 * j -: 8];
            x2 = xtime(a[j]);
            x4 = xtime(x2);
            x8 = xtime(x4);
            m9[j] = x8 ^ a[j];
            m11[j] = x8 ^ x2 ^ a[j];
            m13[j] = x8 ^ x4 ^ a[j];
            m14[j] = x8 ^ x4 ^ x2;
        end
        return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
                m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
                m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
                m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
    endfunction

    function automatic blk_t mix_cols(input blk_t s);
        blk_t r;
        for (int c = 0; c < 4; c++)
        begin
            r[127 - 32 * c -: 32] = mix_col(s[127 - 32 * c -: 32]);
        end
        return r;
    endfunction

    function automatic blk_t inv_mix_cols(input blk_t s);
        blk_t r;
        for (int c = 0; c < 4; c++)
        begin
            r[127 - 32 * c -: 32] = inv_mix_col(s[127 - 32 * c -: 32]);
        end
        return r;
    endfunction

    // SubBytes followed by ShiftRows; byte b of the block sits at bits 127-8b
    function automatic blk_t sub_shift(input blk_t s);
        blk_t r;
        for (int c = 0; c < 4; c++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                r[127 - 8 * (4 * c + j) -: 8] =
                    SBOX[s[127 - 8 * (4 * ((c + j) % 4) + j) -: 8]];
            end
        end
        return r;
    endfunction

    function automatic blk_t inv_sub_shift(input blk_t s);
        blk_t r;
        for (int c = 0; c < 4; c++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                r[127 - 8 * (4 * ((c + j) % 4) + j) -: 8] =
                    INV_SBOX[s[127 - 8 * (4 * c + j) -: 8]];
            end
        end
        return r;
    endfunction

    function automatic blk_t next_key(input blk_t k, input logic [7:0] rc);
        logic [31:0] t, w0, w1, w2, w3;
        t = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

// ----- design/aes_key_sched.sv -----
module aes_key_sched
    import aes_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  blk_t key,
    output logic busy,
    output blk_t rk [11],
    output blk_t imk [10]
);

    logic       busy_reg;
    logic [3:0] step_reg;
    blk_t       cur_reg;
    blk_t       rk_reg [11];
    blk_t       imk_reg [10];
    blk_t       nk;
    logic [3:0] rc_idx;

    assign rc_idx = (step_reg == 4'd0) ? 4'd0 : step_reg - 4'd1;
    assign nk = next_key(cur_reg, RCON[rc_idx]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            step_reg <= 4'd0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            step_reg <= 4'd0;
        end
        else if (busy_reg)
        begin
            if (step_reg == 4'(NUM_ROUNDS))
            begin
                busy_reg <= 1'b0;
            end
            step_reg <= step_reg + 4'd1;
        end
    end

    // one round key per cycle; keep the InvMixColumns form of the previous one
    always_ff @(posedge clk)
    begin
        if (busy_reg && !load)
        begin
            if (step_reg == 4'd0)
            begin
                rk_reg[0] <= key;
                cur_reg   <= key;
            end
            else
            begin
                rk_reg[step_reg]         <= nk;
                cur_reg                  <= nk;
                imk_reg[step_reg - 4'd1] <= inv_mix_cols(cur_reg);
            end
        end
    end

    assign busy = busy_reg;
    assign rk = rk_reg;
    assign imk = imk_reg;

endmodule

// ----- design/aes_round_cell.sv -----
module aes_round_cell
    import aes_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic go,
    input  logic last_round,
    input  ctl_t ctl_in,
    input  blk_t data_in,
    input  blk_t enc_key,
    input  blk_t dec_key,
    output ctl_t ctl_out,
    output blk_t data_out
);

    ctl_t ctl_reg;
    blk_t data_reg;
    blk_t enc_ss, dec_ss, enc_m, dec_m, data_next;

    assign enc_ss = sub_shift(data_in);
    assign dec_ss = inv_sub_shift(data_in);
    assign enc_m  = last_round ? enc_ss : mix_cols(enc_ss);
    assign dec_m  = last_round ? dec_ss : inv_mix_cols(dec_ss);
    assign data_next = (ctl_in.kind == KIND_DECRYPT) ? (dec_m ^ dec_key) : (enc_m ^ enc_key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (go)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            data_reg <= data_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign data_out = data_reg;

endmodule

// ----- design/aes128_block_cipher_unit.sv -----
// channel | handshake            | payload
// in      | in_valid / in_ready  | kind, block_first_half, block_second_half, final_in
// out     | out_valid/ out_ready | result_first_half, result_second_half, final_out
// cfg     | cfg_en               | cfg_index, cfg_data
//
// One item per cycle unless stalled or busy; a key add stage plus ten round cells.
// Each stage advances on its own, so bubbles close up behind a stalled output.
// After reset or a key write the key schedule runs, one round
// key per cycle, with in_ready low; config writes are still taken then.
module aes128_block_cipher_unit
    import aes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [63:0] block_first_half,
    input  logic [63:0] block_second_half,
    input  logic        final_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_first_half,
    output logic [63:0] result_second_half,
    output logic        final_out,
    input  logic        cfg_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0] key_hi_reg, key_lo_reg;
    logic        key_load;
    logic        busy;
    blk_t        rk [11];
    blk_t        imk [10];

    ctl_t        ctl [NUM_ROUNDS + 1];
    blk_t        data [NUM_ROUNDS + 1];
    logic        go [NUM_ROUNDS + 1];

    ctl_t        ctl0_reg;
    blk_t        data0_reg;
    blk_t        blk_in;
    logic        accept;

    assign key_load = cfg_en && (cfg_index == REG_KEY_FIRST || cfg_index == REG_KEY_SECOND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
        end
        else if (cfg_en)
        begin
            if (cfg_index == REG_KEY_FIRST)
            begin
                key_hi_reg <= cfg_data;
            end
            if (cfg_index == REG_KEY_SECOND)
            begin
                key_lo_reg <= cfg_data;
            end
        end
    end

    aes_key_sched u_sched (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (key_load),
        .key   ({key_hi_reg, key_lo_reg}),
        .busy  (busy),
        .rk    (rk),
        .imk   (imk)
    );

    // a stage loads when it is empty or the next stage loads
    always_comb
    begin
        go[NUM_ROUNDS] = !ctl[NUM_ROUNDS].vld || out_ready;
        for (int i = NUM_ROUNDS - 1; i >= 0; i--)
        begin
            go[i] = !ctl[i].vld || go[i + 1];
        end
    end

    assign in_ready = go[0] && !busy;
    assign accept = in_valid && in_ready;
    assign blk_in = {block_first_half, block_second_half};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
        end
        else if (go[0])
        begin
            ctl0_reg <= '{vld: accept, kind: kind, fin: final_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data0_reg <= blk_in ^ ((kind == KIND_DECRYPT) ? rk[NUM_ROUNDS] : rk[0]);
        end
    end

    assign ctl[0] = ctl0_reg;
    assign data[0] = data0_reg;

    for (genvar r = 1; r <= NUM_ROUNDS; r++)
    begin : g_round
        blk_t dkey;
        if (r == NUM_ROUNDS)
        begin : g_last
            assign dkey = rk[0];
        end
        else
        begin : g_mid
            assign dkey = imk[NUM_ROUNDS - r];
        end

        aes_round_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .go         (go[r]),
            .last_round (r == NUM_ROUNDS),
            .ctl_in     (ctl[r - 1]),
            .data_in    (data[r - 1]),
            .enc_key    (rk[r]),
            .dec_key    (dkey),
            .ctl_out    (ctl[r]),
            .data_out   (data[r])
        );
    end

    assign out_valid = ctl[NUM_ROUNDS].vld;
    assign result_first_half = data[NUM_ROUNDS][127:64];
    assign result_second_half = data[NUM_ROUNDS][63:0];
    assign final_out = ctl[NUM_ROUNDS].fin;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ready)
        else $error("item taken while key schedule runs");

    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        key_load |=> busy)
        else $error("key write did not restart schedule");

    a_accept_stage0: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ctl[0].vld)
        else $error("accepted item lost at first stage");

    a_first_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl[0].vld && !go[1]) |-> !in_ready ##1 ctl[0].vld)
        else $error("first stage overwritten while stalled");

endmodule
